FILE: hdl/dtfs_pkg.sv
// shared types and constants of the delimited text field splitter
`default_nettype none
package dtfs_pkg;

  localparam int OFFSET_WIDTH_DEF = 32;
  localparam int CFG_IDX_W        = 3;
  localparam int RES_W            = 32;

  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_NUL = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_DELIM   = 3'd0,
    CFG_COL_DELIM   = 3'd1,
    CFG_ITEM_DELIM  = 3'd2,
    CFG_ESCAPE_BYTE = 3'd3,
    CFG_ESCAPES_ON  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] row_delim;
    logic [7:0] col_delim;
    logic [7:0] item_delim;
    logic [7:0] escape_byte;
    logic       escapes_on;
  } cfg_t;

  typedef struct packed {
    logic [RES_W-1:0] field_start;
    logic [RES_W-1:0] field_length;
    logic             has_escape;
    logic             ends_row;
    logic             last_of_run;
  } result_t;

endpackage
`default_nettype wire

FILE: hdl/dtfs_cfg_regs.sv
// configuration register file of the field splitter
`default_nettype none
module dtfs_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           we_i,
  input  wire logic [dtfs_pkg::CFG_IDX_W-1:0] idx_i,
  input  wire logic [7:0]                     wdata_i,
  output dtfs_pkg::cfg_t                      cfg_o
);

  dtfs_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_delim   <= dtfs_pkg::BYTE_LF;
      cfg_q.col_delim   <= 8'd1;
      cfg_q.item_delim  <= 8'd2;
      cfg_q.escape_byte <= dtfs_pkg::BYTE_NUL;
      cfg_q.escapes_on  <= 1'b0;
    end else if (we_i) begin
      case (idx_i)
        dtfs_pkg::CFG_ROW_DELIM:   cfg_q.row_delim   <= wdata_i;
        dtfs_pkg::CFG_COL_DELIM:   cfg_q.col_delim   <= wdata_i;
        dtfs_pkg::CFG_ITEM_DELIM:  cfg_q.item_delim  <= wdata_i;
        dtfs_pkg::CFG_ESCAPE_BYTE: cfg_q.escape_byte <= wdata_i;
        dtfs_pkg::CFG_ESCAPES_ON:  cfg_q.escapes_on  <= wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

FILE: hdl/dtfs_tracker.sv
// per-byte field tracking state and result decode
`default_nettype none
module dtfs_tracker #(
  parameter int OFFSET_WIDTH = dtfs_pkg::OFFSET_WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dtfs_pkg::cfg_t cfg_i,
  input  wire logic        accept_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        final_byte_i,
  output logic [1:0]       count_o,
  output dtfs_pkg::result_t res0_o,
  output dtfs_pkg::result_t res1_o
);

  logic [OFFSET_WIDTH-1:0] pos_q, pos_d, cfs_q, cfs_d, cfs_a, pos1;
  logic [OFFSET_WIDTH-1:0] len1, len2;
  logic ep_q, ep_d, fe_q, fe_d, acr_q, acr_d;
  logic is_row, is_col, esc_hit, fe1, fe_a, lf_skip, close1, close2;
  dtfs_pkg::result_t c1, c2;

  always_comb begin
    is_row  = !ep_q && (cfg_i.row_delim != dtfs_pkg::BYTE_NUL) &&
              ((data_byte_i == cfg_i.row_delim) ||
               ((cfg_i.row_delim == dtfs_pkg::BYTE_LF) && (data_byte_i == dtfs_pkg::BYTE_CR)));
    is_col  = !ep_q && !is_row &&
              ((data_byte_i == cfg_i.col_delim) || (data_byte_i == cfg_i.item_delim));
    esc_hit = cfg_i.escapes_on && (data_byte_i == cfg_i.escape_byte);
    fe1     = fe_q | esc_hit;
    ep_d    = esc_hit ? !ep_q : 1'b0;
    lf_skip = is_row && acr_q && (data_byte_i == dtfs_pkg::BYTE_LF);
    close1  = (is_row && !lf_skip) || is_col;
    acr_d   = is_row && (data_byte_i == dtfs_pkg::BYTE_CR);
    pos1    = pos_q + 1'b1;

    // first close: the delimiter ends the open field
    len1 = pos_q - cfs_q;
    c1.field_start  = 32'(cfs_q);
    c1.field_length = 32'(len1);
    c1.has_escape   = cfg_i.escapes_on && fe1;
    c1.ends_row     = is_row;
    c1.last_of_run  = 1'b0;

    if (lf_skip) begin
      cfs_a = cfs_q + 1'b1;
    end else if (close1) begin
      cfs_a = pos1;
    end else begin
      cfs_a = cfs_q;
    end
    fe_a = (close1 && cfg_i.escapes_on) ? 1'b0 : fe1;

    // second close: final byte with undelimited rows ends field and row
    close2 = final_byte_i && (cfg_i.row_delim == dtfs_pkg::BYTE_NUL);
    len2 = pos1 - cfs_a;
    c2.field_start  = 32'(cfs_a);
    c2.field_length = 32'(len2);
    c2.has_escape   = cfg_i.escapes_on && fe_a;
    c2.ends_row     = 1'b1;
    c2.last_of_run  = 1'b1;

    cfs_d = close2 ? pos1 : cfs_a;
    fe_d  = (close2 && cfg_i.escapes_on) ? 1'b0 : fe_a;
    pos_d = pos1;

    count_o = {1'b0, close1} + {1'b0, close2};
    res1_o  = c2;
    if (close1) begin
      res0_o = c1;
      res0_o.last_of_run = !close2;
    end else begin
      res0_o = c2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      cfs_q <= '0;
      ep_q  <= 1'b0;
      fe_q  <= 1'b0;
      acr_q <= 1'b0;
    end else if (accept_i) begin
      pos_q <= pos_d;
      cfs_q <= cfs_d;
      ep_q  <= ep_d;
      fe_q  <= fe_d;
      acr_q <= acr_d;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/dtfs_out_buf.sv
// two-slot result register feeding the output stream
`default_nettype none
module dtfs_out_buf (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [1:0]   push_count_i,
  input  wire dtfs_pkg::result_t res0_i,
  input  wire dtfs_pkg::result_t res1_i,
  output logic              can_push_o,
  output logic              valid_o,
  input  wire logic         ready_i,
  output dtfs_pkg::result_t res_o
);

  dtfs_pkg::result_t slot0_q, slot1_q;
  logic [1:0] count_q, count_d;
  logic pop;

  assign pop        = (count_q != 2'd0) && ready_i;
  // a new byte may land once whatever is held leaves this cycle
  assign can_push_o = (count_q == 2'd0) || ((count_q == 2'd1) && ready_i);
  assign valid_o    = (count_q != 2'd0);
  assign res_o      = slot0_q;

  always_comb begin
    count_d = count_q;
    if (push_i) begin
      count_d = push_count_i;
    end else if (pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot0_q <= res0_i;
      slot1_q <= res1_i;
    end else if (pop) begin
      slot0_q <= slot1_q;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/delimited_text_field_splitter.sv
// top level of the delimited text field splitter
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+-------------------------------------------
//  s_axis   | in  | tvalid / tready        | tdata: data_byte, tlast: final_byte
//  m_axis   | out | tvalid / tready        | tdata: field_start, field_length,
//           |     |                        | tuser: has_escape, ends_row, tlast: last_of_run
//  cfg      | in  | cfg_we_i, no wait      | cfg_idx_i register index, cfg_wdata_i value
//
// one byte per clock unless m_axis stalls: the tracker state updates in the cycle a byte transaction
// is accepted and its results land in the two-slot output register
// a byte that closes two fields (final byte, no row delimiter) fills both slots,
// so the next byte waits until the first of them has left the register
// s_axis_tready is high when the output register is empty or its single
// result leaves this cycle; stalls on m_axis back up straight to s_axis
// reset (async, active low) clears offsets, flags and the register defaults
`default_nettype none
module delimited_text_field_splitter #(
  parameter int OFFSET_WIDTH = dtfs_pkg::OFFSET_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic [dtfs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [7:0]                     cfg_wdata_i,
  // input byte stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [7:0]                     s_axis_tdata,   // [7:0] data_byte
  input  wire logic                           s_axis_tlast,   // final_byte
  // field result stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [63:0]                         m_axis_tdata,   // [31:0] field_start, [63:32] field_length
  output logic [1:0]                          m_axis_tuser,   // [0] has_escape, [1] ends_row
  output logic                                m_axis_tlast    // last_of_run
);

  dtfs_pkg::cfg_t    cfg;
  dtfs_pkg::result_t res0, res1, res_out;
  logic [1:0]        res_count;
  logic              accept;
  logic              can_push;

  assign s_axis_tready = can_push;
  assign accept        = s_axis_tvalid && can_push;

  dtfs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  // offsets, escape toggle and cr tracking; decodes up to two closed fields
  dtfs_tracker #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .accept_i     (accept),
    .data_byte_i  (s_axis_tdata),
    .final_byte_i (s_axis_tlast),
    .count_o      (res_count),
    .res0_o       (res0),
    .res1_o       (res1)
  );

  // result register; a byte with no result simply leaves it empty
  dtfs_out_buf u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (accept),
    .push_count_i (res_count),
    .res0_i       (res0),
    .res1_i       (res1),
    .can_push_o   (can_push),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .res_o        (res_out)
  );

  assign m_axis_tdata = {res_out.field_length, res_out.field_start};
  assign m_axis_tuser = {res_out.ends_row, res_out.has_escape};
  assign m_axis_tlast = res_out.last_of_run;

endmodule
`default_nettype wire

FILE: sim/tb_delimited_text_field_splitter.sv
// self-checking testbench for the delimited text field splitter
`default_nettype none
module tb_delimited_text_field_splitter;
  timeunit 1ns;
  timeprecision 1ps;

  // watchdog limit in clock cycles, far above the slowest legal run
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BYTES = 1200;
  localparam int CALM_TAIL = 200;   // last bytes of the run go without idling
  localparam int SETTLE_CYCLES = 4;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #10 clk_i = ~clk_i;

  // block inputs, known from time zero
  logic                           cfg_we_i = 1'b0;
  logic [dtfs_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [7:0]                     cfg_wdata_i = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic [7:0]                     s_axis_tdata = '0;   // [7:0] data_byte
  logic                           s_axis_tlast = 1'b0; // final_byte
  logic                           m_axis_tready = 1'b1;

  // block outputs
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [63:0] m_axis_tdata;  // [31:0] field_start, [63:32] field_length
  logic [1:0]  m_axis_tuser;  // [0] has_escape, [1] ends_row
  logic        m_axis_tlast;  // last_of_run

  delimited_text_field_splitter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // idle pressure in percent per transaction slot, changed per phase
  int src_gap_pct = 25;
  int sink_stall_pct = 25;

  int n_mismatch = 0;
  int unsigned cycles = 0;

  // ---------------------------------------------------------------------------
  // tokenizer model: own copy of registers and tracker state
  // ---------------------------------------------------------------------------
  dtfs_pkg::cfg_t regs_q;
  logic [31:0] pos_q;        // offset of the next byte
  logic [31:0] fstart_q;     // where the open field began
  logic        esc_pend_q;   // previous byte was an active escape
  logic        fld_esc_q;    // open field held an escape byte
  logic        after_cr_q;   // previous byte was a CR that ended a row

  // closed fields still waiting to come out of the block, oldest first
  dtfs_pkg::result_t expected_fields[$];

  task automatic reset_tracker_model();
    regs_q.row_delim   = dtfs_pkg::BYTE_LF;
    regs_q.col_delim   = 8'h01;
    regs_q.item_delim  = 8'h02;
    regs_q.escape_byte = dtfs_pkg::BYTE_NUL;
    regs_q.escapes_on  = 1'b0;
    pos_q      = '0;
    fstart_q   = '0;
    esc_pend_q = 1'b0;
    fld_esc_q  = 1'b0;
    after_cr_q = 1'b0;
  endtask

  // field ends just before end_pos; the next one opens at next_start
  function automatic void close_field(input logic [31:0] end_pos, input logic row_end,
                                      input logic [31:0] next_start);
    dtfs_pkg::result_t r;
    r.field_start  = fstart_q;
    r.field_length = end_pos - fstart_q;
    r.has_escape   = regs_q.escapes_on & fld_esc_q;
    r.ends_row     = row_end;
    r.last_of_run  = 1'b0;
    expected_fields.push_back(r);
    fstart_q = next_start;
    if (regs_q.escapes_on) fld_esc_q = 1'b0;
  endfunction

  task automatic predict_fields(input logic [7:0] b, input logic fin);
    logic              row_end;
    logic              col_end;
    int                n;
    dtfs_pkg::result_t r;
    row_end = 1'b0;
    col_end = 1'b0;
    n = 0;
    // delimiters only count when not escaped
    if (!esc_pend_q) begin
      if (regs_q.row_delim != dtfs_pkg::BYTE_NUL &&
          (b == regs_q.row_delim ||
           (regs_q.row_delim == dtfs_pkg::BYTE_LF && b == dtfs_pkg::BYTE_CR))) begin
        row_end = 1'b1;
        col_end = 1'b1;
      end else if (b == regs_q.col_delim || b == regs_q.item_delim) begin
        col_end = 1'b1;
      end
    end
    // escape toggle, two escapes in a row cancel
    if (regs_q.escapes_on && b == regs_q.escape_byte) begin
      fld_esc_q  = 1'b1;
      esc_pend_q = !esc_pend_q;
    end else begin
      esc_pend_q = 1'b0;
    end
    if (row_end) begin
      // lf right after a cr row end only skips itself
      if (after_cr_q && b == dtfs_pkg::BYTE_LF) begin
        fstart_q = fstart_q + 1;
      end else begin
        close_field(pos_q, 1'b1, pos_q + 1);
        n++;
      end
      after_cr_q = (b == dtfs_pkg::BYTE_CR);
    end else begin
      after_cr_q = 1'b0;
      if (col_end) begin
        close_field(pos_q, 1'b0, pos_q + 1);
        n++;
      end
    end
    pos_q = pos_q + 1;
    // without row delimiter the final byte closes field and row
    if (fin && regs_q.row_delim == dtfs_pkg::BYTE_NUL) begin
      close_field(pos_q, 1'b1, pos_q);
      n++;
    end
    if (n > 0) begin
      r = expected_fields.pop_back();
      r.last_of_run = 1'b1;
      expected_fields.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one byte transaction, with an optional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if ($urandom_range(0, 99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_fields(b, fin);
  endtask

  // sender holds off until every closed field has come out
  task automatic wait_fields_done();
    s_axis_tvalid <= 1'b0;
    while (expected_fields.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write, only called while the block is idle
  task automatic write_reg(input logic [dtfs_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      dtfs_pkg::CFG_ROW_DELIM:   regs_q.row_delim   = val;
      dtfs_pkg::CFG_COL_DELIM:   regs_q.col_delim   = val;
      dtfs_pkg::CFG_ITEM_DELIM:  regs_q.item_delim  = val;
      dtfs_pkg::CFG_ESCAPE_BYTE: regs_q.escape_byte = val;
      dtfs_pkg::CFG_ESCAPES_ON:  regs_q.escapes_on  = val[0];
      default: ;  // unused index, no effect
    endcase
  endtask

  // mostly bytes that matter to the current setting, the rest plain text
  function automatic logic [7:0] pick_text_byte();
    case ($urandom_range(0, 11))
      0:       return regs_q.row_delim;
      1:       return regs_q.col_delim;
      2:       return regs_q.item_delim;
      3, 4:    return regs_q.escape_byte;
      5:       return dtfs_pkg::BYTE_CR;
      6:       return dtfs_pkg::BYTE_LF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // delimiter choice leaning on the extremes
  function automatic logic [7:0] pick_delim(input logic [7:0] usual);
    case ($urandom_range(0, 4))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return usual;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset settings: lf rows, 0x01 fields, 0x02 items, no escapes
  task automatic test_default_delimiters();
    send_byte("a", 1'b0);
    send_byte(8'h01, 1'b0);      // field delimiter
    send_byte(8'hFF, 1'b0);
    send_byte(8'h02, 1'b0);      // item delimiter
    send_byte(8'h00, 1'b0);
    send_byte(dtfs_pkg::BYTE_LF, 1'b0);    // row end
    send_byte(dtfs_pkg::BYTE_CR, 1'b0);    // cr ends the row too
    send_byte(dtfs_pkg::BYTE_LF, 1'b0);    // lf after cr row end only moves the start
    send_byte(dtfs_pkg::BYTE_CR, 1'b0);    // lone cr
    send_byte("c", 1'b1);        // final byte with row delimiter set does nothing extra
    send_byte(dtfs_pkg::BYTE_LF, 1'b0);
    wait_fields_done();
  endtask

  // escape toggling, escaped delimiters and an escape equal to a delimiter
  task automatic test_escapes();
    write_reg(dtfs_pkg::CFG_ESCAPE_BYTE, "\\");
    write_reg(dtfs_pkg::CFG_ESCAPES_ON, 8'h01);
    send_byte("x", 1'b0);
    send_byte("\\", 1'b0);
    send_byte(8'h01, 1'b0);      // escaped, closes nothing
    send_byte("\\", 1'b0);
    send_byte("\\", 1'b0);       // double escape cancels
    send_byte(8'h01, 1'b0);      // closes with has_escape
    send_byte("\\", 1'b0);
    send_byte(dtfs_pkg::BYTE_LF, 1'b0);    // escaped row delimiter
    send_byte(dtfs_pkg::BYTE_LF, 1'b0);
    wait_fields_done();
    write_reg(dtfs_pkg::CFG_ESCAPE_BYTE, 8'h01);
    send_byte(8'h01, 1'b0);      // marks escaped and still closes
    send_byte(8'h01, 1'b0);      // now escaped, closes nothing
    send_byte(8'h01, 1'b0);
    wait_fields_done();
  endtask

  // rows not delimited: final byte closes the row, a final delimiter gives two fields
  task automatic test_undelimited_rows();
    write_reg(dtfs_pkg::CFG_ROW_DELIM, dtfs_pkg::BYTE_NUL);
    write_reg(dtfs_pkg::CFG_COL_DELIM, 8'hFF);
    write_reg(dtfs_pkg::CFG_ITEM_DELIM, 8'h00);
    write_reg(dtfs_pkg::CFG_ESCAPES_ON, 8'h00);
    send_byte("a", 1'b0);
    send_byte("b", 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_fields_done();
  endtask

  // writes to unused indexes change nothing
  task automatic test_unused_indexes();
    for (int i = int'(dtfs_pkg::CFG_ESCAPES_ON) + 1; i < (1 << dtfs_pkg::CFG_IDX_W); i++)
      write_reg(dtfs_pkg::CFG_IDX_W'(i), 8'($urandom_range(0, 255)));
    send_byte("z", 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_fields_done();
  endtask

  // phases of random text, each under a fresh random setting
  task automatic test_random_stream();
    int sent;
    int phase_len;
    int pct_pick;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      case ($urandom_range(0, 5))
        0:       write_reg(dtfs_pkg::CFG_ROW_DELIM, dtfs_pkg::BYTE_NUL);
        1:       write_reg(dtfs_pkg::CFG_ROW_DELIM, dtfs_pkg::BYTE_CR);
        2:       write_reg(dtfs_pkg::CFG_ROW_DELIM, 8'hFF);
        3:       write_reg(dtfs_pkg::CFG_ROW_DELIM, 8'($urandom_range(0, 255)));
        default: write_reg(dtfs_pkg::CFG_ROW_DELIM, dtfs_pkg::BYTE_LF);
      endcase
      write_reg(dtfs_pkg::CFG_COL_DELIM, pick_delim(8'h01));
      write_reg(dtfs_pkg::CFG_ITEM_DELIM, pick_delim(8'h02));
      write_reg(dtfs_pkg::CFG_ESCAPE_BYTE, pick_delim("\\"));
      // upper data bits are don't care for the enable
      write_reg(dtfs_pkg::CFG_ESCAPES_ON,
                {7'($urandom_range(0, 127)), 1'($urandom_range(0, 3) != 0)});
      pct_pick = $urandom_range(0, 2);
      src_gap_pct = (pct_pick == 0) ? 0 : (pct_pick == 1) ? 10 : 40;
      pct_pick = $urandom_range(0, 2);
      sink_stall_pct = (pct_pick == 0) ? 0 : (pct_pick == 1) ? 10 : 40;
      phase_len = $urandom_range(40, 160);
      for (int i = 0; i < phase_len && sent < RANDOM_BYTES; i++) begin
        if (sent >= RANDOM_BYTES - CALM_TAIL) begin
          src_gap_pct = 0;
          sink_stall_pct = 0;
        end
        send_byte(pick_text_byte(), 1'($urandom_range(0, 11) == 0));
        sent++;
        // now and then let everything drain in the middle of a phase
        if (sent < RANDOM_BYTES - CALM_TAIL && $urandom_range(0, 199) == 0)
          wait_fields_done();
      end
      wait_fields_done();
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls and comparison with the oldest expectation
  // ---------------------------------------------------------------------------
  initial begin : sink_ready
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) stall_left--;
      else if ($urandom_range(0, 99) < sink_stall_pct) stall_left = $urandom_range(1, 12);
      m_axis_tready <= (stall_left == 0);
    end
  end

  task automatic flag_mismatch(input string what, input dtfs_pkg::result_t want,
                               input dtfs_pkg::result_t got);
    n_mismatch++;
    if (n_mismatch <= 10)
      $display({"mismatch (%0s): expected start %0d len %0d esc %0b row %0b last %0b,",
                " got start %0d len %0d esc %0b row %0b last %0b"},
               what, want.field_start, want.field_length, want.has_escape, want.ends_row,
               want.last_of_run, got.field_start, got.field_length, got.has_escape,
               got.ends_row, got.last_of_run);
  endtask

  always @(posedge clk_i) begin : field_check
    dtfs_pkg::result_t got;
    dtfs_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.field_start  = m_axis_tdata[31:0];
      got.field_length = m_axis_tdata[63:32];
      got.has_escape   = m_axis_tuser[0];
      got.ends_row     = m_axis_tuser[1];
      got.last_of_run  = m_axis_tlast;
      if (expected_fields.size() == 0) begin
        flag_mismatch("nothing expected", '0, got);
      end else begin
        want = expected_fields.pop_front();
        if (got.field_start !== want.field_start || got.field_length !== want.field_length ||
            got.has_escape !== want.has_escape || got.ends_row !== want.ends_row ||
            got.last_of_run !== want.last_of_run)
          flag_mismatch("field", want, got);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    reset_tracker_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_delimiters();
    test_escapes();
    test_undelimited_rows();
    test_unused_indexes();
    test_random_stream();

    // drain everything and let the pipeline settle before the verdict
    wait_fields_done();
    repeat (8) @(posedge clk_i);
    if (n_mismatch == 0 && expected_fields.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
